// ===== hdl/depq_pkg.sv =====
// ----------------------------------------------------------------------------
// depq_pkg: shared types and constants of the double-ended priority queue
// entry sizes, operation and status codes, cell commands and tree sizing
// ----------------------------------------------------------------------------
package depq_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TAP_W    = VAL_W + 1;   // value in the low bits, duplicate flag on top
  localparam int TAP_DUP  = VAL_W;
  localparam int GROUP    = 16;          // fan-in of one reduction node

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP_MAX = 2'd1,
    OP_POP_MIN = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PROBE,
    CMD_INSERT,
    CMD_POP_MAX,
    CMD_POP_MIN
  } cell_cmd_t;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_t          cmd;
    logic               tap_max;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } cell_ctl_t;

  // what a cell hands to its neighbors
  typedef struct packed {
    logic               valid;
    logic               ge;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
  } link_t;

  // nodes on a level of the reduction tree, level 0 being the cells
  function automatic int node_count(input int lv);
    int n;
    n = CAPACITY;
    for (int i = 0; i < lv; i++) begin
      n = (n + GROUP - 1) / GROUP;
    end
    return n;
  endfunction

  function automatic int tree_levels();
    int l;
    int n;
    l = 1;
    n = node_count(1);
    for (int i = 0; i < 8; i++) begin
      if (n > 1) begin
        n = (n + GROUP - 1) / GROUP;
        l++;
      end
    end
    return l;
  endfunction

  localparam int TREE_LEVELS = tree_levels();
  localparam int LVL_W       = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(TREE_LEVELS - 1);

endpackage

// ===== hdl/depq_cell.sv =====
// ----------------------------------------------------------------------------
// depq_cell: one slot of the sorted chain
// holds one entry, compares it with the broadcast key and shifts with neighbors
// ----------------------------------------------------------------------------
module depq_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  depq_pkg::cell_ctl_t           ctl,
  input  depq_pkg::link_t               from_prev,
  input  depq_pkg::link_t               from_next,
  output depq_pkg::link_t               link,
  output logic [depq_pkg::TAP_W-1:0]    tap
);
  import depq_pkg::*;

  logic             valid;
  logic             ge;
  logic             eq;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  logic             sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.cmd)
        CMD_INSERT: begin
          if (from_prev.ge) begin
            valid <= from_prev.valid;
          end else if (ge) begin
            valid <= 1'b1;
          end
        end
        CMD_POP_MAX: begin
          if (valid && !from_next.valid) begin
            valid <= 1'b0;
          end
        end
        CMD_POP_MIN: valid <= from_next.valid;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_PROBE: begin
        // an empty slot counts as above every key
        ge <= !valid || (key >= ctl.key);
        eq <= valid && (key == ctl.key);
      end
      CMD_INSERT: begin
        if (from_prev.ge) begin
          key   <= from_prev.key;
          value <= from_prev.value;
        end else if (ge) begin
          key   <= ctl.key;
          value <= ctl.value;
        end
      end
      CMD_POP_MIN: begin
        key   <= from_next.key;
        value <= from_next.value;
      end
      default: ;
    endcase
  end

  // top of the run when the next slot is empty, bottom when the previous is
  assign sel = ctl.tap_max ? (valid && !from_next.valid) : (valid && !from_prev.valid);

  assign tap  = {eq, (sel ? value : {VAL_W{1'b0}})};
  assign link = '{valid: valid, ge: ge, key: key, value: value};

endmodule

// ===== hdl/depq_or_tree.sv =====
// ----------------------------------------------------------------------------
// depq_or_tree: registered or-reduction over the cell taps
// one register level per GROUP-wide fan-in, each level adding to the root latency
// ----------------------------------------------------------------------------
module depq_or_tree (
  input  logic                          clk,
  input  logic [depq_pkg::TAP_W-1:0]    leaf [depq_pkg::CAPACITY],
  output logic [depq_pkg::TAP_W-1:0]    root
);
  import depq_pkg::*;

  logic [TAP_W-1:0] lvl [TREE_LEVELS+1][CAPACITY];

  for (genvar lv = 1; lv <= TREE_LEVELS; lv++) begin : g_lvl
    for (genvar j = 0; j < node_count(lv); j++) begin : g_node
      logic [TAP_W-1:0] grp [GROUP];
      logic [TAP_W-1:0] acc;

      for (genvar k = 0; k < GROUP; k++) begin : g_in
        if (j * GROUP + k >= node_count(lv - 1)) begin : g_pad
          assign grp[k] = '0;
        end else if (lv == 1) begin : g_leaf
          assign grp[k] = leaf[j * GROUP + k];
        end else begin : g_inner
          assign grp[k] = lvl[lv-1][j * GROUP + k];
        end
      end

      always_comb begin
        acc = '0;
        for (int k = 0; k < GROUP; k++) begin
          acc = acc | grp[k];
        end
      end

      always_ff @(posedge clk) begin
        lvl[lv][j] <= acc;
      end
    end
  end

  assign root = lvl[TREE_LEVELS][0];

endmodule

// ===== hdl/double_ended_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_top: sorted double-ended priority queue
// up to CAPACITY unique 64-bit keys with signed 32-bit values, pop max or min
// ----------------------------------------------------------------------------
// The entries sit in a chain of CAPACITY cells, sorted by ascending key from
// cell 0 up, the occupied cells always forming one run starting at cell 0.
// Each request is handled on its own: the port takes one beat, works on it and
// takes the next once the work is done; a finished result may wait in the
// output register while the next beat is already accepted. An insert goes
// through accepting the beat, every cell comparing its key with the new one,
// the registered or-tree finding whether the key is already stored, and the
// cells above the insertion point shifting up. A pop goes through accepting
// the beat and the tree fetching the value of the top or bottom cell. A pop
// on an empty queue and the unused operation code need no lookup. The last
// step waits while the previous result has not been taken. The or-tree has
// one register level per factor of 16 in capacity. A duplicate key is
// reported and ignores the new value; an insert of a new key into a full
// queue is reported as dropped; a pop on an empty queue returns value 0.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_top (
  input  logic         clk,
  input  logic         rst,
  // request channel
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // [63:0] priority_key, [95:64] payload
  input  logic [1:0]   s_tuser,   // [1:0] operation
  // result channel
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // [31:0] value_out
  output logic [2:0]   m_tuser    // [2:0] status
);
  import depq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_REDUCE,
    S_APPLY
  } state_t;

  state_t           state;
  logic [1:0]       op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  logic [LVL_W-1:0] lvl_cnt;
  logic [CNT_W-1:0] count;

  logic             out_free;
  logic             apply_fire;
  logic             is_pop;
  logic             dup;
  logic             do_insert;
  logic             do_pop;
  logic [TAP_W-1:0] root;
  cell_ctl_t        ctl;

  link_t            links   [CAPACITY];
  link_t            prev_lk [CAPACITY];
  link_t            next_lk [CAPACITY];
  logic [TAP_W-1:0] taps    [CAPACITY];

  // ---- control decisions ----
  assign out_free   = !m_tvalid || m_tready;
  assign apply_fire = (state == S_APPLY) && out_free;
  assign is_pop     = (op == OP_POP_MAX) || (op == OP_POP_MIN);
  assign dup        = root[TAP_DUP];
  // insert goes ahead only for a new key with room left
  assign do_insert  = (op == OP_INSERT) && !dup && (count != CAP_COUNT);
  assign do_pop     = is_pop && (count != '0);

  assign s_tready = (state == S_IDLE);

  always_comb begin
    ctl.cmd     = CMD_HOLD;
    ctl.tap_max = (op == OP_POP_MAX);
    ctl.key     = key;
    ctl.value   = value;
    case (state)
      S_PROBE: ctl.cmd = CMD_PROBE;
      S_APPLY: begin
        if (apply_fire && do_insert) begin
          ctl.cmd = CMD_INSERT;
        end else if (apply_fire && do_pop) begin
          ctl.cmd = (op == OP_POP_MAX) ? CMD_POP_MAX : CMD_POP_MIN;
        end
      end
      default: ;
    endcase
  end

  // ---- sequencer and result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      lvl_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result leaves unless a new one is loaded in the same cycle
      if (m_tvalid && m_tready && !apply_fire) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= s_tuser;
            key     <= s_tdata[KEY_W-1:0];
            value   <= s_tdata[KEY_W +: VAL_W];
            lvl_cnt <= '0;
            if (s_tuser == OP_INSERT) begin
              state <= S_PROBE;
            end else if (((s_tuser == OP_POP_MAX) || (s_tuser == OP_POP_MIN)) &&
                         (count != '0)) begin
              state <= S_REDUCE;
            end else begin
              // empty queue or unused code: nothing to look up
              state <= S_APPLY;
            end
          end
        end
        S_PROBE: state <= S_REDUCE;
        S_REDUCE: begin
          if (lvl_cnt == LVL_LAST) begin
            state <= S_APPLY;
          end else begin
            lvl_cnt <= lvl_cnt + 1'b1;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
            if (op == OP_INSERT) begin
              m_tdata <= '0;
              if (dup) begin
                m_tuser <= ST_DUPLICATE;
              end else if (count == CAP_COUNT) begin
                m_tuser <= ST_FULL;
              end else begin
                m_tuser <= ST_INSERTED;
                count   <= count + 1'b1;
              end
            end else if (do_pop) begin
              m_tuser <= ST_POPPED;
              m_tdata <= root[VAL_W-1:0];
              count   <= count - 1'b1;
            end else begin
              m_tuser <= ST_EMPTY;
              m_tdata <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- chain of cells ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_lk[i] = '0;
    end else begin : g_mid_lo
      assign prev_lk[i] = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_lk[i] = '0;
    end else begin : g_mid_hi
      assign next_lk[i] = links[i+1];
    end

    depq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .from_prev (prev_lk[i]),
      .from_next (next_lk[i]),
      .link      (links[i]),
      .tap       (taps[i])
    );
  end

  // duplicate flag and selected value gathered over the chain
  depq_or_tree u_tree (
    .clk  (clk),
    .leaf (taps),
    .root (root)
  );

endmodule

// ===== tb/double_ended_priority_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_top_test: self-checking bench of the queue
// drives insert, pop-max, pop-min and unused-code beats with random gaps,
// keeps a sorted copy of the store and checks every result beat against it
// ----------------------------------------------------------------------------
module double_ended_priority_queue_top_test;
  import depq_pkg::*;

  // operation code with no meaning, answered as empty
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles without any accepted beat before the run is stopped as failed
  localparam int IDLE_LIMIT = 1000;
  // cycles left to run after the last result, beyond the longest insert
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] key;
    logic [31:0] payload;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] val;
  } result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // [63:0] priority_key, [95:64] payload
  logic [1:0]  s_tuser;   // [1:0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] value_out
  logic [2:0]  m_tuser;   // [2:0] status

  // requests waiting to be driven, results still owed by the block
  request_t    pending_requests[$];
  result_t     expected_results[$];
  // keys handed out so far, drawn from again to make duplicate inserts
  logic [63:0] issued_keys[$];
  // bench copy of the store, ascending by key
  logic [63:0] store_keys[$];
  logic [31:0] store_vals[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  // handshakes seen at the last rising edge, read at the falling edge
  bit in_taken    = 0;
  bit out_taken   = 0;

  double_ended_priority_queue_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // queue behavior: one result per request, store updated in place
  // ---------------------------------------------------------------------------
  task automatic apply_request(input logic [1:0] op, input logic [63:0] key,
                               input logic [31:0] val);
    int      pos;
    result_t res;
    res.status = ST_EMPTY;
    res.val    = '0;
    if (op == OP_INSERT) begin
      pos = 0;
      while (pos < store_keys.size() && store_keys[pos] < key) pos++;
      if (pos < store_keys.size() && store_keys[pos] == key) begin
        // stored value wins, even when the store is full
        res.status = ST_DUPLICATE;
      end else if (store_keys.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        store_keys.insert(pos, key);
        store_vals.insert(pos, val);
        res.status = ST_INSERTED;
      end
    end else if (op != OP_UNUSED && store_keys.size() != 0) begin
      res.status = ST_POPPED;
      if (op == OP_POP_MAX) begin
        res.val = store_vals.pop_back();
        void'(store_keys.pop_back());
      end else begin
        res.val = store_vals.pop_front();
        void'(store_keys.pop_front());
      end
    end
    // empty store and the unused code fall through with status empty, value 0
    expected_results.push_back(res);
  endtask

  task automatic note_mismatch(input string what, input result_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s): expected status %0d value %0d, got status %0d value %0d",
               what, want.status, $signed(want.val), m_tuser, $signed(m_tdata));
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_request(input logic [1:0] op, input logic [63:0] key,
                             input logic [31:0] payload);
    request_t req;
    req.op      = op;
    req.key     = key;
    req.payload = payload;
    pending_requests.push_back(req);
    if (op == OP_INSERT) issued_keys.push_back(key);
  endtask

  // dup_pct percent of the time reuse a key already issued, else a fresh one
  function automatic logic [63:0] pick_key(input int dup_pct);
    if (issued_keys.size() > 0 && $urandom_range(0, 99) < dup_pct) begin
      return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    end
    case ($urandom_range(0, 9))
      0:       return 64'($urandom_range(0, 15));
      1:       return ~64'd0 - 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [1:0] pick_pop();
    return $urandom_range(0, 1) ? OP_POP_MAX : OP_POP_MIN;
  endfunction

  // pops carry random key and payload bits, which the block must ignore
  task automatic add_pop(input logic [1:0] op);
    add_request(op, {$urandom, $urandom}, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: changes at the falling edge, one beat held until taken
  // ---------------------------------------------------------------------------
  int       in_wait  = 0;
  bit       in_quiet = 0;
  request_t drive_req;

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (in_wait > 0) begin
          s_tvalid <= 1'b0;
          in_wait  = in_wait - 1;
        end else if (pending_requests.size() > 0) begin
          drive_req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {drive_req.payload, drive_req.key};
          s_tuser  <= drive_req.op;
          // now and then switch between gapped and back-to-back stretches
          if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
          in_wait = in_quiet ? 0 : $urandom_range(0, 19);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side backpressure: a random stall before each result beat
  // ---------------------------------------------------------------------------
  int out_wait  = 0;
  bit out_quiet = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        out_wait = out_quiet ? 0 : $urandom_range(0, 19);
      end
      if (out_wait > 0) begin
        m_tready <= 1'b0;
        out_wait = out_wait - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    in_taken  = 0;
    out_taken = 0;
    if (!rst) begin
      // request first, so its expectation is queued before any check
      if (s_tvalid && s_tready) begin
        in_taken = 1;
        apply_request(s_tuser, s_tdata[63:0], s_tdata[95:64]);
      end
      if (m_tvalid && m_tready) begin
        out_taken = 1;
        if (expected_results.size() == 0) begin
          want.status = ST_EMPTY;
          want.val    = '0;
          note_mismatch("unexpected beat", want);
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.status || m_tdata !== want.val) begin
            note_mismatch("field", want);
          end
        end
      end
      // watchdog on cycles with no beat on either side
      if (in_taken || out_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_INSERT;
    m_tready = 1'b0;

    // directed: empty pops, unused code, key and payload extremes, duplicate
    add_pop(OP_POP_MAX);
    add_pop(OP_POP_MIN);
    add_pop(OP_UNUSED);
    add_request(OP_INSERT, 64'd0, 32'h8000_0000);
    add_request(OP_INSERT, ~64'd0, 32'h7fff_ffff);
    add_request(OP_INSERT, 64'd0, 32'h1234_5678);        // duplicate, value kept
    add_request(OP_INSERT, ~64'd0, 32'h0000_0000);       // duplicate at the top
    add_request(OP_INSERT, 64'h8000_0000_0000_0000, 32'hffff_ffff);
    add_request(OP_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h0000_0001);
    add_pop(OP_UNUSED);                                   // empty answer, store kept
    add_pop(OP_POP_MAX);
    add_pop(OP_POP_MIN);
    add_pop(OP_POP_MAX);
    add_pop(OP_POP_MIN);
    add_pop(OP_POP_MIN);                                  // pop on the store just drained
    add_request(OP_INSERT, 64'd1, 32'h0000_0000);
    add_request(OP_INSERT, 64'h5555_5555_5555_5555, 32'haaaa_aaaa);
    add_request(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555);
    add_pop(OP_POP_MIN);
    add_pop(OP_POP_MAX);
    add_pop(OP_POP_MAX);
    add_pop(OP_POP_MAX);

    // fill past capacity: full drops and duplicates against a full store
    for (int i = 0; i < 340; i++) begin
      if ($urandom_range(0, 99) < 95) begin
        add_request(OP_INSERT, pick_key(8), $urandom);
      end else begin
        add_pop(pick_pop());
      end
    end
    // drain down to empty and beyond
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(0, 99) < 92) begin
        add_pop(pick_pop());
      end else begin
        add_request(OP_INSERT, pick_key(20), $urandom);
      end
    end
    // mixed traffic on a narrow key range so duplicates and empties are common
    for (int i = 0; i < 400; i++) begin
      case ($urandom_range(0, 99)) inside
        [0:47]:  add_request(OP_INSERT,
                             $urandom_range(0, 3) == 0 ? pick_key(30)
                                                       : 64'($urandom_range(0, 47)),
                             $urandom);
        [48:96]: add_pop(pick_pop());
        default: add_pop(OP_UNUSED);
      endcase
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all requests taken and every result back, then let the block settle
    while (!(pending_requests.size() == 0 && !s_tvalid && expected_results.size() == 0))
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches = mismatches + expected_results.size();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== double_ended_priority_queue_top.f =====
hdl/depq_pkg.sv
hdl/depq_cell.sv
hdl/depq_or_tree.sv
hdl/double_ended_priority_queue_top.sv
tb/double_ended_priority_queue_top_test.sv
